// File: src/utrb_pkg.sv
// ---------------------------------------------------------------------------
// utrb_pkg: shared types and constants for the UART TX/RX ring buffer pair
// Ring depth, index and count types, payload structs, op codes, controller
// states and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package utrb_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t LAST_IDX  = idx_t'(DEPTH - 1);
  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  typedef enum logic [2:0] {
    OP_PUT_TX   = 3'd0,
    OP_GET_RX   = 3'd1,
    OP_RX_BYTE  = 3'd2,
    OP_TX_READY = 3'd3,
    OP_FLUSH_RX = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] send_byte;
    logic       send_valid;
    logic       put_accepted;
    logic       rx_dropped;
    logic [7:0] tx_count;
    logic [7:0] rx_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } dp_status_t;

endpackage

// File: src/utrb_ram.sv
// ---------------------------------------------------------------------------
// utrb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module utrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/utrb_ctrl.sv
// ---------------------------------------------------------------------------
// utrb_ctrl: sequencing controller
// Walks one item through load, execute, optional RAM fetch and response.
// ---------------------------------------------------------------------------
module utrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  utrb_pkg::dp_status_t   status,
  output utrb_pkg::ctrl_cmd_t    cmd
);

  utrb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utrb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      utrb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = utrb_pkg::ST_EXEC;
      end
      utrb_pkg::ST_EXEC: begin
        state_nxt = status.need_fetch ? utrb_pkg::ST_FETCH : utrb_pkg::ST_RESP;
      end
      utrb_pkg::ST_FETCH: begin
        state_nxt = utrb_pkg::ST_RESP;
      end
      utrb_pkg::ST_RESP: begin
        if (out_ready) state_nxt = utrb_pkg::ST_IDLE;
      end
      default: state_nxt = utrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      utrb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      utrb_pkg::ST_EXEC:  cmd.exec  = 1'b1;
      utrb_pkg::ST_FETCH: cmd.fetch = 1'b1;
      utrb_pkg::ST_RESP:  out_valid = 1'b1;
      default: ;
    endcase
  end

  a_fetch_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == utrb_pkg::ST_FETCH |-> $past(state_r) == utrb_pkg::ST_EXEC)
    else $error("fetch entered without execute");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.fetch}))
    else $error("more than one datapath command");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

endmodule

// File: src/utrb_dp.sv
// ---------------------------------------------------------------------------
// utrb_dp: ring buffer datapath
// Ring indices, the two byte stores and the result register.
// ---------------------------------------------------------------------------
module utrb_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utrb_pkg::in_t        in_data,
  input  utrb_pkg::ctrl_cmd_t  cmd,
  output utrb_pkg::dp_status_t status,
  output utrb_pkg::out_t       out_data
);

  function automatic utrb_pkg::idx_t ring_next(utrb_pkg::idx_t i);
    return (i == utrb_pkg::LAST_IDX) ? '0 : i + utrb_pkg::idx_t'(1);
  endfunction

  function automatic logic [7:0] ring_count(utrb_pkg::idx_t w, utrb_pkg::idx_t r);
    utrb_pkg::cnt_t d;
    if (w >= r) begin
      d = utrb_pkg::cnt_t'(w) - utrb_pkg::cnt_t'(r);
    end else begin
      d = utrb_pkg::DEPTH_CNT + utrb_pkg::cnt_t'(w) - utrb_pkg::cnt_t'(r);
    end
    return 8'(d);
  endfunction

  logic [2:0]      op_r;
  logic [7:0]      data_r;
  utrb_pkg::idx_t  tx_wr_r, tx_rd_r, rx_wr_r, rx_rd_r;
  utrb_pkg::idx_t  tx_wr_nxt, tx_rd_nxt, rx_wr_nxt, rx_rd_nxt;
  utrb_pkg::out_t  res_r, res_nxt;
  logic            fetch_tx_r;

  logic tx_full, tx_empty, rx_full, rx_empty;
  logic tx_we, tx_re, rx_we, rx_re;
  logic [7:0] tx_rdata, rx_rdata;

  assign tx_empty = (tx_wr_r == tx_rd_r);
  assign rx_empty = (rx_wr_r == rx_rd_r);
  assign tx_full  = (ring_next(tx_wr_r) == tx_rd_r);
  assign rx_full  = (ring_next(rx_wr_r) == rx_rd_r);

  assign tx_we = cmd.exec && (op_r == utrb_pkg::OP_PUT_TX)   && !tx_full;
  assign tx_re = cmd.exec && (op_r == utrb_pkg::OP_TX_READY) && !tx_empty;
  assign rx_we = cmd.exec && (op_r == utrb_pkg::OP_RX_BYTE)  && !rx_full;
  assign rx_re = cmd.exec && (op_r == utrb_pkg::OP_GET_RX)   && !rx_empty;

  assign status.need_fetch = tx_re || rx_re;

  utrb_ram #(.WIDTH(8), .DEPTH(utrb_pkg::DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_r),
    .wdata (data_r),
    .re    (tx_re),
    .raddr (tx_rd_r),
    .rdata (tx_rdata)
  );

  utrb_ram #(.WIDTH(8), .DEPTH(utrb_pkg::DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_r),
    .wdata (data_r),
    .re    (rx_re),
    .raddr (rx_rd_r),
    .rdata (rx_rdata)
  );

  // next indices for the op being executed
  always_comb begin
    tx_wr_nxt = tx_wr_r;
    tx_rd_nxt = tx_rd_r;
    rx_wr_nxt = rx_wr_r;
    rx_rd_nxt = rx_rd_r;
    if (tx_we) tx_wr_nxt = ring_next(tx_wr_r);
    if (tx_re) tx_rd_nxt = ring_next(tx_rd_r);
    if (rx_we) rx_wr_nxt = ring_next(rx_wr_r);
    if (rx_re) rx_rd_nxt = ring_next(rx_rd_r);
    if (cmd.exec && (op_r == utrb_pkg::OP_FLUSH_RX)) begin
      rx_wr_nxt = '0;
      rx_rd_nxt = '0;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.exec) begin
      res_nxt              = '0;
      res_nxt.read_valid   = rx_re;
      res_nxt.send_valid   = tx_re;
      res_nxt.put_accepted = tx_we;
      res_nxt.rx_dropped   = cmd.exec && (op_r == utrb_pkg::OP_RX_BYTE) && rx_full;
      res_nxt.tx_count     = ring_count(tx_wr_nxt, tx_rd_nxt);
      res_nxt.rx_count     = ring_count(rx_wr_nxt, rx_rd_nxt);
    end else if (cmd.fetch) begin
      // capture the registered RAM read issued during execute
      if (fetch_tx_r) begin
        res_nxt.send_byte = tx_rdata;
      end else begin
        res_nxt.read_byte = rx_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_r <= '0;
      tx_rd_r <= '0;
      rx_wr_r <= '0;
      rx_rd_r <= '0;
    end else begin
      tx_wr_r <= tx_wr_nxt;
      tx_rd_r <= tx_rd_nxt;
      rx_wr_r <= rx_wr_nxt;
      rx_rd_r <= rx_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.op;
      data_r <= in_data.data_byte;
    end
    if (cmd.exec) begin
      fetch_tx_r <= tx_re;
    end
    res_r <= res_nxt;
  end

  assign out_data = res_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_wr_r <= utrb_pkg::LAST_IDX && tx_rd_r <= utrb_pkg::LAST_IDX &&
    rx_wr_r <= utrb_pkg::LAST_IDX && rx_rd_r <= utrb_pkg::LAST_IDX)
    else $error("ring index out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == utrb_pkg::OP_FLUSH_RX |=> rx_wr_r == '0 && rx_rd_r == '0)
    else $error("flush left rx indices set");

  a_tx_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (op_r == utrb_pkg::OP_GET_RX || op_r == utrb_pkg::OP_RX_BYTE ||
                 op_r == utrb_pkg::OP_FLUSH_RX)
    |=> $stable(tx_wr_r) && $stable(tx_rd_r))
    else $error("rx-side op moved tx indices");

endmodule

// File: src/uart_tx_rx_ring_buffers.sv
// ---------------------------------------------------------------------------
// uart_tx_rx_ring_buffers: TX and RX byte ring buffer pair
// Channel  | Ports                          | Moves
// input    | in_valid, in_ready, in_data    | one op and data byte per transfer
// result   | out_valid, out_ready, out_data | one result per accepted op
//
// One item is in flight at a time: accept, execute, then a fetch step for a
// get or transmit that returns a byte from a ring's RAM read port, then the
// result is held in its register until out_ready takes it.
// Reset clears the ring indices and the controller; stores need no clearing.
// ---------------------------------------------------------------------------
module uart_tx_rx_ring_buffers (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  utrb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output utrb_pkg::out_t out_data
);

  utrb_pkg::ctrl_cmd_t  cmd;
  utrb_pkg::dp_status_t status;

  utrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  utrb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
